>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by header_block_deframer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising edge of clk, off while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/hbd_pkg.sv
// ----------------------------------------------------------------------------
// hbd_pkg
// Request and result types and codes for the header block deframer.
// ----------------------------------------------------------------------------
package hbd_pkg;

  localparam int unsigned HeaderBytes = 3;

  localparam logic [2:0] ROLE_VERSION   = 3'd0;
  localparam logic [2:0] ROLE_COUNT     = 3'd1;
  localparam logic [2:0] ROLE_NAME_LEN  = 3'd2;
  localparam logic [2:0] ROLE_VALUE_LEN = 3'd3;
  localparam logic [2:0] ROLE_NAME      = 3'd4;
  localparam logic [2:0] ROLE_VALUE     = 3'd5;
  localparam logic [2:0] ROLE_IGNORED   = 3'd6;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_VERSION   = 3'd2;
  localparam logic [2:0] ST_TRUNCATED = 3'd3;
  localparam logic [2:0] ST_ZERO_NAME = 3'd4;
  localparam logic [2:0] ST_TRAILING  = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_block;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [2:0]  byte_role;
    logic [15:0] field_number;
    logic        field_end;
    logic        block_done;
    logic [2:0]  status;
  } out_item_t;

endpackage

>>> design/header_block_deframer.sv
// A request accepted into the input register is parsed there, and its result is registered into out_data.
// Throughput: one byte per cycle while out_stall is low; an input register and a result register
// part the two sides, so a byte is taken while one result waits.
// Reset (rst, synchronous): empties both registers, clears the parse state
// to await a version byte, and sets expected_version to 1.
// ----------------------------------------------------------------------------
// header_block_deframer
// Checks and splits a length-prefixed header block, one byte per request.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module header_block_deframer
  import hbd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata
);

  typedef enum logic [2:0] {
    PH_VERSION   = 3'd0,
    PH_COUNT     = 3'd1,
    PH_NAME_LEN  = 3'd2,
    PH_VALUE_LEN = 3'd3,
    PH_NAME      = 3'd4,
    PH_VALUE     = 3'd5,
    PH_DONE      = 3'd6
  } phase_t;

  logic [7:0]  expected_version;
  logic        s1_valid;
  in_item_t    s1_item;
  logic        s2_load;

  phase_t      phase, phase_next;
  logic [1:0]  header_bytes_seen, header_bytes_seen_next;
  logic [15:0] fields_left, fields_left_next;
  logic [7:0]  name_bytes_left, name_bytes_left_next;
  logic [15:0] value_bytes_left, value_bytes_left_next;
  logic [15:0] current_field, current_field_next;
  logic [2:0]  error_code, error_code_next;
  logic        low_byte_next, low_byte_next_next;
  out_item_t   result;

  assign s2_load  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s2_load;

  always_comb begin
    logic [7:0]  b;
    logic [15:0] fl_dec;
    logic [7:0]  nb_dec;
    logic [15:0] vb_dec;
    b      = s1_item.data_byte;
    fl_dec = fields_left - 16'd1;
    nb_dec = name_bytes_left - 8'd1;
    vb_dec = value_bytes_left - 16'd1;

    phase_next             = phase;
    fields_left_next       = fields_left;
    name_bytes_left_next   = name_bytes_left;
    value_bytes_left_next  = value_bytes_left;
    current_field_next     = current_field;
    error_code_next        = error_code;
    low_byte_next_next     = low_byte_next;
    header_bytes_seen_next = header_bytes_seen;
    if (header_bytes_seen < 2'(HeaderBytes)) begin
      header_bytes_seen_next = header_bytes_seen + 2'd1;
    end

    result.byte_out     = b;
    result.byte_role    = ROLE_IGNORED;
    result.field_number = '0;
    result.field_end    = 1'b0;
    result.block_done   = s1_item.end_of_block;
    result.status       = ST_OK;

    if (error_code == ST_OK) begin
      case (phase)
        PH_VERSION: begin
          result.byte_role = ROLE_VERSION;
          if (b != expected_version) begin
            error_code_next = ST_VERSION;
          end
          phase_next         = PH_COUNT;
          low_byte_next_next = 1'b0;
        end
        PH_COUNT: begin
          result.byte_role = ROLE_COUNT;
          if (!low_byte_next) begin
            fields_left_next   = {b, 8'h00};
            low_byte_next_next = 1'b1;
          end else begin
            fields_left_next   = {fields_left[15:8], b};
            low_byte_next_next = 1'b0;
            phase_next = ({fields_left[15:8], b} != 16'd0) ? PH_NAME_LEN : PH_DONE;
          end
        end
        PH_NAME_LEN: begin
          result.byte_role     = ROLE_NAME_LEN;
          result.field_number  = current_field;
          name_bytes_left_next = b;
          phase_next           = PH_VALUE_LEN;
          low_byte_next_next   = 1'b0;
        end
        PH_VALUE_LEN: begin
          result.byte_role    = ROLE_VALUE_LEN;
          result.field_number = current_field;
          if (!low_byte_next) begin
            value_bytes_left_next = {b, 8'h00};
            low_byte_next_next    = 1'b1;
          end else begin
            value_bytes_left_next = {value_bytes_left[15:8], b};
            low_byte_next_next    = 1'b0;
            if (name_bytes_left == 8'd0) begin
              error_code_next = ST_ZERO_NAME;
            end else begin
              phase_next = PH_NAME;
            end
          end
        end
        PH_NAME: begin
          result.byte_role     = ROLE_NAME;
          result.field_number  = current_field;
          name_bytes_left_next = nb_dec;
          if (nb_dec == 8'd0) begin
            result.field_end = 1'b1;
            if (value_bytes_left == 16'd0) begin
              current_field_next = current_field + 16'd1;
              fields_left_next   = fl_dec;
              phase_next         = (fl_dec != 16'd0) ? PH_NAME_LEN : PH_DONE;
            end else begin
              phase_next = PH_VALUE;
            end
          end
        end
        PH_VALUE: begin
          result.byte_role      = ROLE_VALUE;
          result.field_number   = current_field;
          value_bytes_left_next = vb_dec;
          if (vb_dec == 16'd0) begin
            result.field_end   = 1'b1;
            current_field_next = current_field + 16'd1;
            fields_left_next   = fl_dec;
            phase_next         = (fl_dec != 16'd0) ? PH_NAME_LEN : PH_DONE;
          end
        end
        default: begin
          error_code_next = ST_TRAILING;
        end
      endcase
    end

    if (s1_item.end_of_block) begin
      if (header_bytes_seen_next < 2'(HeaderBytes)) begin
        result.status = ST_SHORT;
      end else if (error_code_next != ST_OK) begin
        result.status = error_code_next;
      end else if (phase_next != PH_DONE) begin
        result.status = ST_TRUNCATED;
      end else begin
        result.status = ST_OK;
      end
      // restart for the next block
      phase_next             = PH_VERSION;
      header_bytes_seen_next = '0;
      fields_left_next       = '0;
      name_bytes_left_next   = '0;
      value_bytes_left_next  = '0;
      current_field_next     = '0;
      error_code_next        = ST_OK;
      low_byte_next_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version  <= 8'd1;
      s1_valid          <= 1'b0;
      out_valid         <= 1'b0;
      phase             <= PH_VERSION;
      header_bytes_seen <= '0;
      fields_left       <= '0;
      name_bytes_left   <= '0;
      value_bytes_left  <= '0;
      current_field     <= '0;
      error_code        <= ST_OK;
      low_byte_next     <= 1'b0;
    end else begin
      if (cfg_we) begin
        expected_version <= cfg_wdata;
      end
      if (in_valid && !in_stall) begin
        s1_item <= in_data;
      end
      s1_valid  <= (in_valid && !in_stall) || (s1_valid && !s2_load);
      out_valid <= s2_load || (out_valid && out_stall);
      if (s2_load) begin
        out_data          <= result;
        phase             <= phase_next;
        header_bytes_seen <= header_bytes_seen_next;
        fields_left       <= fields_left_next;
        name_bytes_left   <= name_bytes_left_next;
        value_bytes_left  <= value_bytes_left_next;
        current_field     <= current_field_next;
        error_code        <= error_code_next;
        low_byte_next     <= low_byte_next_next;
      end
    end
  end

  `ASSERT_CLK(a_status_only_at_end,
    !out_valid || out_data.block_done || out_data.status == ST_OK,
    "status set on a result that does not end the block")
  `ASSERT_CLK(a_ignored_clean,
    !out_valid || out_data.byte_role != ROLE_IGNORED ||
    (out_data.field_number == 16'd0 && !out_data.field_end),
    "ignored byte carries field information")
  `ASSERT_NEXT(a_restart_after_end, s2_load && s1_item.end_of_block,
    phase == PH_VERSION && error_code == ST_OK && header_bytes_seen == 2'd0,
    "parse state not cleared after block end")
  `ASSERT_NEXT(a_error_latched, error_code != ST_OK && !s2_load,
    $stable(error_code), "latched error changed without a request")

endmodule

>>> bench/tb_header_block_deframer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_header_block_deframer
// Self-checking bench for the header block deframer. Sends directed and
// random header blocks (well-formed, truncated, short, wrong version, zero
// name length, trailing bytes, noise) under several expected versions, with
// random gaps on both handshakes, and checks every result against a
// cycle-free prediction of the parse.
// ----------------------------------------------------------------------------
module tb_header_block_deframer;
  import hbd_pkg::*;

  typedef enum logic [2:0] {
    PH_VERSION, PH_COUNT, PH_NAME_LEN, PH_VALUE_LEN, PH_NAME, PH_VALUE, PH_DONE
  } parse_phase_t;

  typedef logic [7:0] byte_q_t[$];

  class deframe_predictor;
    logic [7:0]   version_reg;
    parse_phase_t phase;
    logic [1:0]   hdr_seen;
    logic [15:0]  fields_left;
    logic [7:0]   name_left;
    logic [15:0]  value_left;
    logic [15:0]  cur_field;
    logic [2:0]   err;
    bit           low_next;
    out_item_t    expected_tags[$];
    int           errors;

    function new();
      version_reg = 8'h01;
      errors = 0;
      clear();
    endfunction

    function void clear();
      phase = PH_VERSION;
      hdr_seen = '0;
      fields_left = '0;
      name_left = '0;
      value_left = '0;
      cur_field = '0;
      err = ST_OK;
      low_next = 1'b0;
    endfunction

    function void close_field();
      cur_field = cur_field + 16'd1;
      fields_left = fields_left - 16'd1;
      phase = (fields_left != 0) ? PH_NAME_LEN : PH_DONE;
    endfunction

    function void take_request(in_item_t req);
      out_item_t  want;
      logic [7:0] b;
      b = req.data_byte;
      want = '0;
      want.byte_out = b;
      want.byte_role = ROLE_IGNORED;
      want.block_done = req.end_of_block;
      if (hdr_seen < HeaderBytes) hdr_seen++;
      if (err == ST_OK) begin
        case (phase)
          PH_VERSION: begin
            want.byte_role = ROLE_VERSION;
            if (b != version_reg) err = ST_VERSION;
            phase = PH_COUNT;
            low_next = 1'b0;
          end
          PH_COUNT: begin
            want.byte_role = ROLE_COUNT;
            if (!low_next) begin
              fields_left = {b, 8'h00};
              low_next = 1'b1;
            end else begin
              fields_left = {fields_left[15:8], b};
              low_next = 1'b0;
              phase = (fields_left != 0) ? PH_NAME_LEN : PH_DONE;
            end
          end
          PH_NAME_LEN: begin
            want.byte_role = ROLE_NAME_LEN;
            want.field_number = cur_field;
            name_left = b;
            phase = PH_VALUE_LEN;
            low_next = 1'b0;
          end
          PH_VALUE_LEN: begin
            want.byte_role = ROLE_VALUE_LEN;
            want.field_number = cur_field;
            if (!low_next) begin
              value_left = {b, 8'h00};
              low_next = 1'b1;
            end else begin
              value_left = {value_left[15:8], b};
              low_next = 1'b0;
              if (name_left == 0) err = ST_ZERO_NAME;
              else phase = PH_NAME;
            end
          end
          PH_NAME: begin
            want.byte_role = ROLE_NAME;
            want.field_number = cur_field;
            name_left = name_left - 8'd1;
            if (name_left == 0) begin
              want.field_end = 1'b1;
              if (value_left == 0) close_field();
              else phase = PH_VALUE;
            end
          end
          PH_VALUE: begin
            want.byte_role = ROLE_VALUE;
            want.field_number = cur_field;
            value_left = value_left - 16'd1;
            if (value_left == 0) begin
              want.field_end = 1'b1;
              close_field();
            end
          end
          default: err = ST_TRAILING;
        endcase
      end
      if (req.end_of_block) begin
        if (hdr_seen < HeaderBytes) want.status = ST_SHORT;
        else if (err != ST_OK) want.status = err;
        else if (phase != PH_DONE) want.status = ST_TRUNCATED;
        else want.status = ST_OK;
        clear();
      end
      expected_tags = {expected_tags, want};
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_tags.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %p", got);
        return;
      end
      want = expected_tags.pop_front();
      if (got.byte_out !== want.byte_out || got.byte_role !== want.byte_role ||
          got.field_number !== want.field_number || got.field_end !== want.field_end ||
          got.block_done !== want.block_done || got.status !== want.status) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch %0t expected byte %h role %0d field %0d end %b done %b status %0d",
                   $realtime, want.byte_out, want.byte_role, want.field_number,
                   want.field_end, want.block_done, want.status);
          $display("  got byte %h role %0d field %0d end %b done %b status %0d",
                   got.byte_out, got.byte_role, got.field_number, got.field_end,
                   got.block_done, got.status);
        end
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_data;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  deframe_predictor predictor = new();
  bit steady_flow;
  int bytes_sent;

  header_block_deframer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int draw_gap();
    if (steady_flow) return 0;
    return $urandom_range(0, 1) ? 0 : $urandom_range(1, 16);
  endfunction

  // hold each request until taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, end_of_block: last};
    do @(posedge clk); while (in_stall);
    predictor.take_request(in_data);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_block(input byte_q_t blk);
    steady_flow = ($urandom_range(0, 5) == 0);
    foreach (blk[i]) send_byte(blk[i], i == blk.size() - 1);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (predictor.expected_tags.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_version(input logic [7:0] v);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    predictor.version_reg = v;
  endtask

  task automatic make_block(input logic [7:0] ver, input int nf, input int zero_at,
                            output byte_q_t blk);
    int nlen;
    int vlen;
    int r;
    blk = {};
    blk = {blk, ver};
    blk = {blk, 8'(nf >> 8)};
    blk = {blk, 8'(nf)};
    for (int f = 0; f < nf; f++) begin
      nlen = ($urandom_range(0, 49) == 0) ? 255 : $urandom_range(1, 6);
      if (f == zero_at) nlen = 0;
      r = $urandom_range(0, 39);
      vlen = (r == 0) ? $urandom_range(256, 300) : (r < 8) ? 0 : $urandom_range(1, 6);
      blk = {blk, 8'(nlen)};
      blk = {blk, 8'(vlen >> 8)};
      blk = {blk, 8'(vlen)};
      repeat (nlen + vlen) blk = {blk, 8'($urandom)};
    end
  endtask

  task automatic make_random_block(input logic [7:0] ver, output byte_q_t blk);
    int kind;
    int cut;
    int nf;
    kind = $urandom_range(0, 11);
    nf = $urandom_range(0, 4);
    if (kind == 9) begin
      nf = $urandom_range(1, 4);
      make_block(ver, nf, $urandom_range(0, nf - 1), blk);
    end else begin
      make_block(ver, nf, -1, blk);
    end
    case (kind)
      6: begin
        if ($urandom_range(0, 1)) begin
          blk[1] = 8'($urandom);
          blk[2] = 8'($urandom);
        end
        cut = $urandom_range(1, blk.size() > 1 ? blk.size() - 1 : 1);
        while (blk.size() > cut) void'(blk.pop_back());
      end
      7: repeat ($urandom_range(1, 4)) blk = {blk, 8'($urandom)};
      8: blk[0] = ver ^ 8'($urandom_range(1, 255));
      10: begin
        blk = {};
        blk = {blk, ($urandom_range(0, 1) ? ver : 8'($urandom))};
        if ($urandom_range(0, 1)) blk = {blk, 8'($urandom)};
      end
      11: begin
        blk = {};
        repeat ($urandom_range(1, 8)) blk = {blk, 8'($urandom)};
      end
      default: ;
    endcase
  endtask

  // drain results, stalling at random
  initial begin
    int wait_n;
    out_stall = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      wait_n = draw_gap();
      if (wait_n != 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      predictor.check_result(out_data);
      @(negedge clk);
    end
  end

  initial begin
    byte_q_t    blk;
    logic [7:0] versions[6];
    int         phase_start;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    steady_flow = 1'b0;
    bytes_sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    blk = '{8'h01, 8'h00, 8'h00};
    send_block(blk);
    blk = '{8'hFF};
    send_block(blk);
    blk = '{8'h01, 8'h00, 8'h01, 8'h01, 8'h00, 8'h01, 8'h41, 8'h42};
    send_block(blk);
    blk = '{8'h01, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01};
    send_block(blk);
    blk = '{8'h01, 8'h00, 8'h00, 8'hFF};
    send_block(blk);
    blk = '{8'h00, 8'h00, 8'h00};
    send_block(blk);

    versions = '{8'h00, 8'hFF, 8'($urandom), 8'h01, 8'($urandom), 8'($urandom)};
    foreach (versions[p]) begin
      settle();
      write_version(versions[p]);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 90) begin
        make_random_block(versions[p], blk);
        send_block(blk);
      end
    end

    settle();
    repeat (4) @(negedge clk);
    if (predictor.errors == 0 && predictor.expected_tags.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
